// ===== rtl/kem_pkg.sv =====
package kem_pkg;

   localparam int KEY_COUNT = 24;
   localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   localparam int LEVELS_W  = 24;
   localparam int INDEX_W   = 5;
   localparam int NOTE_W    = 7;
   localparam int VEL_W     = 7;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [NOTE_W-1:0] RESET_BASE_NOTE   = 7'd84;
   localparam logic [VEL_W-1:0]  RESET_ON_VELOCITY = 7'd100;

   // register index, taken from paddr[2]
   localparam logic REG_BASE_NOTE   = 1'b0;
   localparam logic REG_ON_VELOCITY = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;   // take a new scan sample
      logic emit;   // write current key into the result register
      logic step;   // advance to the next key
   } cmd_type;

   typedef struct packed {
      logic any_pending;  // changed keys left in this scan
      logic hit;          // current key changed
      logic out_free;     // result register can take an item
   } status_type;

endpackage

// ===== rtl/kem_csr.sv =====
module kem_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [kem_pkg::ADDR_W-1:0]      paddr,
   input  logic [kem_pkg::DATA_W-1:0]      pwdata,
   output logic [kem_pkg::DATA_W-1:0]      prdata,
   output logic                            pready,
   output logic [kem_pkg::NOTE_W-1:0]      base_note,
   output logic [kem_pkg::VEL_W-1:0]       on_velocity
);

   logic [kem_pkg::NOTE_W-1:0] base_note_ff;
   logic [kem_pkg::VEL_W-1:0]  on_velocity_ff;
   logic                       wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_note_ff   <= kem_pkg::RESET_BASE_NOTE;
         on_velocity_ff <= kem_pkg::RESET_ON_VELOCITY;
      end else if (wr_en) begin
         if (paddr[2] == kem_pkg::REG_BASE_NOTE) begin
            base_note_ff <= pwdata[kem_pkg::NOTE_W-1:0];
         end else begin
            on_velocity_ff <= pwdata[kem_pkg::VEL_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == kem_pkg::REG_BASE_NOTE) begin
         prdata = kem_pkg::DATA_W'(base_note_ff);
      end else begin
         prdata = kem_pkg::DATA_W'(on_velocity_ff);
      end
   end

   assign base_note   = base_note_ff;
   assign on_velocity = on_velocity_ff;

endmodule

// ===== rtl/kem_ctrl.sv =====
module kem_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kem_pkg::status_type  status,
   output kem_pkg::cmd_type     cmd
);

   kem_pkg::state_type state_ff;
   kem_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kem_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         kem_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kem_pkg::ST_SCAN;
            end
         end
         kem_pkg::ST_SCAN: begin
            if (!status.any_pending) begin
               state_in = kem_pkg::ST_IDLE;
            end else if (status.hit) begin
               // hold on this key until the result register frees up
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.step = 1'b1;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = kem_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/kem_dp.sv =====
module kem_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  kem_pkg::cmd_type                 cmd,
   output kem_pkg::status_type              status,
   input  logic [kem_pkg::LEVELS_W-1:0]     req_key_levels,
   input  logic [kem_pkg::NOTE_W-1:0]       base_note,
   input  logic [kem_pkg::VEL_W-1:0]        on_velocity,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_note_on,
   output logic [kem_pkg::INDEX_W-1:0]      rsp_key_index,
   output logic [kem_pkg::NOTE_W-1:0]       rsp_note_number,
   output logic [kem_pkg::VEL_W-1:0]        rsp_velocity,
   output logic                             rsp_last_of_scan
);

   localparam int KC = kem_pkg::KEY_COUNT;
   localparam int KW = kem_pkg::KEY_W;

   logic [KC-1:0] prev_ff, prev_in;
   logic [KC-1:0] now_ff, now_in;
   logic [KC-1:0] pend_ff, pend_in;
   logic [KW-1:0] idx_ff, idx_in;

   logic                        valid_ff, valid_in;
   logic                        note_on_ff;
   logic [kem_pkg::INDEX_W-1:0] key_index_ff;
   logic [kem_pkg::NOTE_W-1:0]  note_number_ff;
   logic [kem_pkg::VEL_W-1:0]   velocity_ff;
   logic                        last_ff;

   logic [31:0]                 levels_ext;
   logic [KC-1:0]               sample;
   logic [KC-1:0]               key_sel;
   logic [kem_pkg::NOTE_W:0]    note_diff;
   logic [kem_pkg::NOTE_W-1:0]  note_sat;
   logic                        rising;
   logic                        out_free;

   assign levels_ext = 32'(req_key_levels);
   assign sample     = levels_ext[KC-1:0];
   assign key_sel    = KC'(1) << idx_ff;
   assign rising     = now_ff[idx_ff];
   assign out_free   = !valid_ff || rsp_ready;

   // note below zero saturates
   assign note_diff = {1'b0, base_note} - (kem_pkg::NOTE_W + 1)'(idx_ff);
   assign note_sat  = note_diff[kem_pkg::NOTE_W] ? '0 : note_diff[kem_pkg::NOTE_W-1:0];

   assign status.any_pending = |pend_ff;
   assign status.hit         = pend_ff[idx_ff];
   assign status.out_free    = out_free;

   always_comb begin
      prev_in  = prev_ff;
      now_in   = now_ff;
      pend_in  = pend_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.load) begin
         now_in  = sample;
         pend_in = sample ^ prev_ff;
         prev_in = sample;
         idx_in  = '0;
      end
      if (cmd.emit) begin
         pend_in  = pend_ff & ~key_sel;
         valid_in = 1'b1;
      end
      if (cmd.step) begin
         idx_in = idx_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '1;
         pend_ff  <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         pend_ff  <= pend_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      if (cmd.emit) begin
         note_on_ff     <= rising;
         key_index_ff   <= kem_pkg::INDEX_W'(idx_ff);
         note_number_ff <= note_sat;
         velocity_ff    <= rising ? on_velocity : '0;
         last_ff        <= ((pend_ff & ~key_sel) == '0);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_note_on      = note_on_ff;
   assign rsp_key_index    = key_index_ff;
   assign rsp_note_number  = note_number_ff;
   assign rsp_velocity     = velocity_ff;
   assign rsp_last_of_scan = last_ff;

endmodule

// ===== rtl/key_edge_to_midi_note_events_top.sv =====
// Keys are checked one per cycle in index order while the output register can take a result;
// a changed key is held while rsp_ready is low and a result is still waiting.
// The first result comes from the lowest changed key and is registered when the scan reaches it.
// Results leave through a single output register; a new sample is taken once the scan ends.
// Reset: stored levels all high, base_note 84, on_velocity 100, no result pending.
module key_edge_to_midi_note_events_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [kem_pkg::LEVELS_W-1:0]     req_key_levels,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_note_on,
   output logic [kem_pkg::INDEX_W-1:0]      rsp_key_index,
   output logic [kem_pkg::NOTE_W-1:0]       rsp_note_number,
   output logic [kem_pkg::VEL_W-1:0]        rsp_velocity,
   output logic                             rsp_last_of_scan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [kem_pkg::ADDR_W-1:0]       paddr,
   input  logic [kem_pkg::DATA_W-1:0]       pwdata,
   output logic [kem_pkg::DATA_W-1:0]       prdata,
   output logic                             pready
);

   kem_pkg::cmd_type            cmd;
   kem_pkg::status_type         status;
   logic [kem_pkg::NOTE_W-1:0]  base_note;
   logic [kem_pkg::VEL_W-1:0]   on_velocity;

   kem_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .base_note   (base_note),
      .on_velocity (on_velocity)
   );

   kem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kem_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_key_levels   (req_key_levels),
      .base_note        (base_note),
      .on_velocity      (on_velocity),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_note_on      (rsp_note_on),
      .rsp_key_index    (rsp_key_index),
      .rsp_note_number  (rsp_note_number),
      .rsp_velocity     (rsp_velocity),
      .rsp_last_of_scan (rsp_last_of_scan)
   );

endmodule

// ===== dv/key_edge_to_midi_note_events_top_tb.sv =====
`timescale 1ns / 100ps

module key_edge_to_midi_note_events_top_tb;

   typedef struct packed {
      logic                                note_on;
      logic [kem_pkg::INDEX_W-1:0]         key_index;
      logic [kem_pkg::NOTE_W-1:0]          note_number;
      logic [kem_pkg::VEL_W-1:0]           velocity;
      logic                                last_of_scan;
   } note_event_type;

   class note_event_board;
      logic [kem_pkg::NOTE_W-1:0]    base_note;
      logic [kem_pkg::VEL_W-1:0]     on_velocity;
      logic [kem_pkg::KEY_COUNT-1:0] held_levels;
      note_event_type                due_events[$];
      int                            errors;

      function new();
         base_note   = kem_pkg::RESET_BASE_NOTE;
         on_velocity = kem_pkg::RESET_ON_VELOCITY;
         held_levels = '1;
         errors      = 0;
      endfunction

      function int pending();
         return due_events.size();
      endfunction

      function void set_reg(input logic idx, input logic [kem_pkg::DATA_W-1:0] value);
         if (idx == kem_pkg::REG_BASE_NOTE) begin
            base_note = value[kem_pkg::NOTE_W-1:0];
         end else begin
            on_velocity = value[kem_pkg::VEL_W-1:0];
         end
      endfunction

      // one event per changed key, lowest index first
      function void note_scan(input logic [kem_pkg::LEVELS_W-1:0] levels);
         logic [kem_pkg::KEY_COUNT-1:0] now;
         logic [kem_pkg::KEY_COUNT-1:0] changed;
         note_event_type                ev;
         int                            top;
         now     = levels[kem_pkg::KEY_COUNT-1:0];
         changed = now ^ held_levels;
         top     = -1;
         for (int k = 0; k < kem_pkg::KEY_COUNT; k++) begin
            if (changed[k]) top = k;
         end
         for (int k = 0; k < kem_pkg::KEY_COUNT; k++) begin
            if (changed[k]) begin
               ev.note_on      = now[k];
               ev.key_index    = k[kem_pkg::INDEX_W-1:0];
               ev.note_number  = (int'(base_note) >= k) ?
                                 kem_pkg::NOTE_W'(int'(base_note) - k) : '0;
               ev.velocity     = now[k] ? on_velocity : '0;
               ev.last_of_scan = (k == top);
               due_events.push_back(ev);
            end
         end
         held_levels = now;
      endfunction

      function void compare_field(input string name, input int want, input int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_event(input note_event_type got);
         note_event_type want;
         if (due_events.size() == 0) begin
            $display("%0t: unexpected note event, got on=%0d key=%0d note=%0d vel=%0d last=%0d",
                     $time, got.note_on, got.key_index, got.note_number, got.velocity,
                     got.last_of_scan);
            errors++;
         end else begin
            want = due_events.pop_front();
            compare_field("note_on", want.note_on, got.note_on);
            compare_field("key_index", want.key_index, got.key_index);
            compare_field("note_number", want.note_number, got.note_number);
            compare_field("velocity", want.velocity, got.velocity);
            compare_field("last_of_scan", want.last_of_scan, got.last_of_scan);
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [kem_pkg::LEVELS_W-1:0]     req_key_levels;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_note_on;
   logic [kem_pkg::INDEX_W-1:0]      rsp_key_index;
   logic [kem_pkg::NOTE_W-1:0]       rsp_note_number;
   logic [kem_pkg::VEL_W-1:0]        rsp_velocity;
   logic                             rsp_last_of_scan;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [kem_pkg::ADDR_W-1:0]       paddr;
   logic [kem_pkg::DATA_W-1:0]       pwdata;
   logic [kem_pkg::DATA_W-1:0]       prdata;
   logic                             pready;

   note_event_board                  sb = new();
   int                               send_gap_pct = 0;
   int                               stall_pct = 0;
   logic [kem_pkg::LEVELS_W-1:0]     scan_levels = '1;

   key_edge_to_midi_note_events_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_levels   (req_key_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_note_on      (rsp_note_on),
      .rsp_key_index    (rsp_key_index),
      .rsp_note_number  (rsp_note_number),
      .rsp_velocity     (rsp_velocity),
      .rsp_last_of_scan (rsp_last_of_scan),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // results are checked before a new item is noted: they belong to older scans
   always @(posedge clock) begin : monitor
      note_event_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.note_on      = rsp_note_on;
            got.key_index    = rsp_key_index;
            got.note_number  = rsp_note_number;
            got.velocity     = rsp_velocity;
            got.last_of_scan = rsp_last_of_scan;
            sb.check_event(got);
         end
         if (req_valid && req_ready) sb.note_scan(req_key_levels);
         if (psel && penable && pwrite && pready) sb.set_reg(paddr[2], pwdata);
      end
   end

   // all tasks are entered and left at a falling edge
   task automatic wait_drained();
      while (sb.pending() != 0) @(negedge clock);
      repeat (kem_pkg::KEY_COUNT + 4) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [6:0] value);
      req_valid = 1'b0;
      wait_drained();
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = ($urandom & 32'hFFFF_FF80) | kem_pkg::DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic send_scan(input logic [kem_pkg::LEVELS_W-1:0] levels);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid      = 1'b1;
      req_key_levels = levels;
      scan_levels    = levels;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // mostly a few keys moving at once, some quiet scans, some wild ones
   function automatic logic [kem_pkg::LEVELS_W-1:0] next_scan(
      input logic [kem_pkg::LEVELS_W-1:0] cur);
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return cur;
      if (pick < 25) return kem_pkg::LEVELS_W'($urandom);
      if (pick < 32) return ($urandom_range(1) != 0) ? '1 : '0;
      if (pick < 60) begin
         return cur ^ (kem_pkg::LEVELS_W'(1) << $urandom_range(kem_pkg::KEY_COUNT - 1));
      end
      return cur ^ kem_pkg::LEVELS_W'($urandom & $urandom & $urandom);
   endfunction

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_key_levels = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset config: quiet scans, all keys down, all up, alternating keys, single keys at both ends
      send_scan(24'hFFFFFF);
      send_scan(24'h000000);
      send_scan(24'hFFFFFF);
      send_scan(24'hAAAAAA);
      send_scan(24'h555555);
      send_scan(24'h555555);
      send_scan(24'hFFFFFE);
      send_scan(24'hFFFFFF);
      send_scan(24'h7FFFFF);
      send_scan(24'hFFFFFF);
      send_scan(24'h800001);
      send_scan(24'hFFFFFF);

      write_reg(kem_pkg::REG_BASE_NOTE, 7'd127);
      write_reg(kem_pkg::REG_ON_VELOCITY, 7'd127);
      send_scan(24'h000000);
      send_scan(24'hFFFFFF);

      // base below the key span: high keys clamp at note zero
      write_reg(kem_pkg::REG_BASE_NOTE, 7'd0);
      write_reg(kem_pkg::REG_ON_VELOCITY, 7'd0);
      send_scan(24'h000000);
      send_scan(24'h123456);
      send_scan(24'hFFFFFF);

      write_reg(kem_pkg::REG_BASE_NOTE, 7'd23);
      write_reg(kem_pkg::REG_ON_VELOCITY, 7'd1);
      send_scan(24'h000000);
      send_scan(24'hFFFFFF);

      for (int phase = 0; phase < 4; phase++) begin
         write_reg(kem_pkg::REG_BASE_NOTE, 7'($urandom_range(127)));
         write_reg(kem_pkg::REG_ON_VELOCITY, 7'($urandom_range(127)));
         send_gap_pct = (phase == 1) ? 65 : (phase == 3) ? 12 : 0;
         stall_pct    = (phase == 2) ? 65 : (phase == 3) ? 12 : 0;
         repeat (78) begin
            if ($urandom_range(19) == 0) begin
               req_valid = 1'b0;
               while (sb.pending() != 0) @(negedge clock);
            end
            send_scan(next_scan(scan_levels));
         end
      end

      req_valid = 1'b0;
      wait_drained();
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
